// File: rtl/core/slip_frame_deframer_defines.svh
// Assertion macros used by the checker file.
`ifndef SLIP_FRAME_DEFRAMER_DEFINES_SVH
`define SLIP_FRAME_DEFRAMER_DEFINES_SVH

// Property checked on every rising clk edge, off while rst is high.
`define SFD_ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, off while rst is high.
`define SFD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int CFG_W       = 9;
  localparam int FRAME_LEN_W = 9;
  localparam int WORD_W      = 64;
  localparam int COUNT_W     = 32;

  localparam logic [7:0] BYTE_END     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 9'd20;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 9'd296;

  // configuration register indexes
  localparam logic [0:0] REG_MIN_FRAME_LENGTH = 1'b0;
  localparam logic [0:0] REG_MAX_FRAME_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

endpackage

// File: rtl/core/sfd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module sfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 37
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/slip_frame_deframer.sv
`timescale 1ns / 1ps

// SLIP receive deframer. One wire byte is taken per cycle while in_ready is
// high; escapes are undone and data bytes are packed into 8-byte words, each
// full word written to the frame RAM, the open word kept in a register. An
// END closing a frame of at least min_frame_length bytes counts a good frame
// and drains it as little-endian 64-bit words on the out channel, last one
// flagged; in_ready is low during the drain, which for each word does a RAM
// read, then an output register load, and can be held by out_ready stalls.
// Runts, empty frames and every other byte need no drain. Overflow past
// max_frame_length (capped at FRAME_BYTES) counts once and drops bytes up
// to the next END. Counters wrap at 32 bits. Configuration must be written
// only while idle by the user; the block itself does not enforce it.
module slip_frame_deframer #(
  parameter int FRAME_BYTES = 296
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write_enable,
  input  logic [0:0]                    cfg_index,
  input  logic [sfd_pkg::CFG_W-1:0]     cfg_data,
  // wire byte requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    wire_byte,
  // frame word requests
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfd_pkg::WORD_W-1:0]    frame_data,
  output logic [3:0]                    valid_bytes,
  output logic                          last_word,
  output logic [sfd_pkg::FRAME_LEN_W-1:0] frame_length,
  output logic [sfd_pkg::COUNT_W-1:0]   good_frame_total,
  output logic [sfd_pkg::COUNT_W-1:0]   runt_frame_total,
  output logic [sfd_pkg::COUNT_W-1:0]   overflow_total
);

  import sfd_pkg::*;

  localparam int STORE_WORDS = (FRAME_BYTES + 7) / 8;
  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int FW = $clog2(FRAME_BYTES + 1);
  // compare width covering both the fill count and the 9-bit registers
  localparam int CW = (FW > CFG_W) ? FW : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] min_frame_length;
  logic [CFG_W-1:0] max_frame_length;

  // control state
  state_t          state, state_next;
  logic            escape_pending;
  logic            discarding;
  logic [FW-1:0]   fill_count;
  logic [COUNT_W-1:0] good_frames, runt_frames, overflow_frames;

  // datapath registers
  logic [WORD_W-1:0] open_word;   // word still being filled
  logic [FW-1:0]     drain_len;
  logic [AW-1:0]     drain_last;  // index of final word
  logic [AW-1:0]     word_idx;

  // RAM port signals
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [WORD_W-1:0] ram_rd_data;

  // decode of the accepted byte
  logic              in_fire;
  logic              is_end, is_esc;
  logic [7:0]        data_byte;
  logic              append_req, end_req;
  logic              store_full;
  logic              append_ok, overflow_hit;
  logic              deliver, deliver_good;
  logic [CW-1:0]     limit;
  logic [FW-1:0]     fill_minus_one;

  // drain path
  logic              out_free, out_load;
  logic              word_is_last, word_partial;
  logic [WORD_W-1:0] word_src, word_masked;
  logic [3:0]        word_bytes;

  sfd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (word_idx),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------
  // Byte decode. An escaped byte is always data, even an escaped END.
  // ---------------------------------------------------------------------
  always_comb begin
    in_fire = in_valid && in_ready;
    is_end  = (wire_byte == BYTE_END);
    is_esc  = (wire_byte == BYTE_ESC);

    if (escape_pending && wire_byte == BYTE_ESC_END) begin
      data_byte = BYTE_END;
    end else if (escape_pending && wire_byte == BYTE_ESC_ESC) begin
      data_byte = BYTE_ESC;
    end else begin
      data_byte = wire_byte;
    end

    append_req = in_fire && (escape_pending || (!is_end && !is_esc));
    end_req    = in_fire && !escape_pending && is_end;

    // effective limit is max_frame_length capped at the store size
    if (CW'(max_frame_length) > CW'(FRAME_BYTES)) begin
      limit = CW'(FRAME_BYTES);
    end else begin
      limit = CW'(max_frame_length);
    end
    store_full = (CW'(fill_count) >= limit);

    append_ok    = append_req && !discarding && !store_full;
    overflow_hit = append_req && !discarding && store_full;

    deliver      = end_req && !discarding && (fill_count != '0);
    deliver_good = deliver && (CW'(fill_count) >= CW'(min_frame_length));

    fill_minus_one = fill_count - FW'(1);
  end

  // full words go to RAM as their eighth byte arrives
  always_comb begin
    ram_wr_en   = append_ok && (fill_count[2:0] == 3'd7);
    ram_wr_addr = fill_count[3 +: AW];
    ram_wr_data = {data_byte, open_word[55:0]};
  end

  // ---------------------------------------------------------------------
  // Drain word select: final partial word comes from the open word
  // register, all others from RAM. Bytes past the frame end read as zero.
  // ---------------------------------------------------------------------
  always_comb begin
    word_is_last = (word_idx == drain_last);
    word_partial = word_is_last && (drain_len[2:0] != 3'd0);
    word_src     = word_partial ? open_word : ram_rd_data;
    word_bytes   = word_partial ? {1'b0, drain_len[2:0]} : 4'd8;
    for (int i = 0; i < 8; i++) begin
      word_masked[i*8 +: 8] = (4'(i) < word_bytes) ? word_src[i*8 +: 8] : 8'h00;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (deliver_good) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_load) begin
          state_next = word_is_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_free  = !out_valid || out_ready;
    in_ready  = 1'b0;
    ram_rd_en = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ: begin
        ram_rd_en = 1'b1;
      end
      S_LOAD: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      min_frame_length <= MIN_LEN_RESET;
      max_frame_length <= MAX_LEN_RESET;
      escape_pending   <= 1'b0;
      discarding       <= 1'b0;
      fill_count       <= '0;
      good_frames      <= '0;
      runt_frames      <= '0;
      overflow_frames  <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write_enable) begin
        case (cfg_index)
          REG_MIN_FRAME_LENGTH: min_frame_length <= cfg_data;
          REG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
          default: ;
        endcase
      end

      if (in_fire) begin
        escape_pending <= !escape_pending && is_esc;
      end

      if (overflow_hit) begin
        discarding <= 1'b1;
      end else if (end_req) begin
        discarding <= 1'b0;
      end

      if (append_ok) begin
        fill_count <= fill_count + FW'(1);
      end else if (overflow_hit || end_req) begin
        fill_count <= '0;
      end

      if (overflow_hit) begin
        overflow_frames <= overflow_frames + COUNT_W'(1);
      end
      if (deliver_good) begin
        good_frames <= good_frames + COUNT_W'(1);
      end else if (deliver) begin
        runt_frames <= runt_frames + COUNT_W'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (append_ok) begin
      open_word[fill_count[2:0]*8 +: 8] <= data_byte;
    end

    if (deliver_good) begin
      drain_len  <= fill_count;
      drain_last <= fill_minus_one[3 +: AW];
      word_idx   <= '0;
    end else if (out_load) begin
      word_idx <= word_idx + AW'(1);
    end

    // counters cannot move during a drain, so every word sees the same totals
    if (out_load) begin
      frame_data       <= word_masked;
      valid_bytes      <= word_bytes;
      last_word        <= word_is_last;
      frame_length     <= FRAME_LEN_W'(drain_len);
      good_frame_total <= good_frames;
      runt_frame_total <= runt_frames;
      overflow_total   <= overflow_frames;
    end
  end

endmodule

// File: rtl/core/sfd_checker.sv
`timescale 1ns / 1ps

`include "slip_frame_deframer_defines.svh"

module sfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    wire_byte,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sfd_pkg::WORD_W-1:0]    frame_data,
  input logic [3:0]                    valid_bytes,
  input logic                          last_word,
  input logic [sfd_pkg::FRAME_LEN_W-1:0] frame_length
);

  import sfd_pkg::*;

  // stalled word holds
  `SFD_ASSERT_PROP(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(frame_data) && $stable(last_word) && $stable(valid_bytes), "stalled output word changed")

  // byte count in range, only the final word may be short
  `SFD_ASSERT_IMPL(a_word_bytes, out_valid, valid_bytes != 4'd0 && valid_bytes <= 4'd8 && (last_word || valid_bytes == 4'd8), "bad valid_bytes")

  // a word never claims more bytes than its frame holds
  `SFD_ASSERT_IMPL(a_len_bound, out_valid, frame_length != '0 && FRAME_LEN_W'(valid_bytes) <= frame_length, "valid_bytes exceeds frame_length")

  // input stalls only after a frame-closing END
  `SFD_ASSERT_IMPL(a_stall_cause, $fell(in_ready), $past(in_valid && wire_byte == BYTE_END), "in_ready dropped without END")

endmodule

bind slip_frame_deframer sfd_checker u_sfd_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

// SLIP deframer bench: bytes go in on the wire request channel, decoded frame words
// come back on the frame word channel and are matched against a local decoder model.
module testbench;
  import sfd_pkg::*;

  localparam int STORE_BYTES  = 296;        // FRAME_BYTES default of the block
  localparam int ITEM_TARGET  = 410;        // wire bytes in the whole run
  localparam int QUIET_AFTER  = 370;        // no idling on either side past this point
  localparam int IDLE_SETTLE  = 8;          // runts/empties need no drain, margin on top
  localparam int DRAIN_SETTLE = 2 * 37 + 16; // one full-frame drain plus margin

  typedef enum logic {ROW_BYTE, ROW_SETTINGS} row_kind_t;

  // one request on the frame word channel
  typedef struct packed {
    logic [WORD_W-1:0]      data;
    logic [3:0]             nbytes;
    logic                   last;
    logic [FRAME_LEN_W-1:0] len;
    logic [COUNT_W-1:0]     good;
    logic [COUNT_W-1:0]     runt;
    logic [COUNT_W-1:0]     ovf;
  } frame_word_t;

  // directed table row: a wire byte, or a new pair of length limits
  typedef struct packed {
    row_kind_t        kind;
    logic [7:0]       wbyte;
    logic [CFG_W-1:0] min_len;
    logic [CFG_W-1:0] max_len;
    logic             typed;   // word below is the hand-written expectation
    frame_word_t      word;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_enable;
  logic [0:0]             cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             wire_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [WORD_W-1:0]      frame_data;
  logic [3:0]             valid_bytes;
  logic                   last_word;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic [COUNT_W-1:0]     good_frame_total;
  logic [COUNT_W-1:0]     runt_frame_total;
  logic [COUNT_W-1:0]     overflow_total;

  slip_frame_deframer u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .wire_byte        (wire_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_data       (frame_data),
    .valid_bytes      (valid_bytes),
    .last_word        (last_word),
    .frame_length     (frame_length),
    .good_frame_total (good_frame_total),
    .runt_frame_total (runt_frame_total),
    .overflow_total   (overflow_total)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: own copy of the escape/discard state, byte store and counters.
  // ---------------------------------------------------------------------------
  bit             esc_seen    = 1'b0;
  bit             dropping    = 1'b0;
  int unsigned    stored_len  = 0;
  logic [7:0]     frame_bytes [STORE_BYTES];
  logic [31:0]    good_count  = '0;
  logic [31:0]    runt_count  = '0;
  logic [31:0]    ovf_count   = '0;
  int unsigned    min_len_cfg = 32'(MIN_LEN_RESET);
  int unsigned    max_len_cfg = 32'(MAX_LEN_RESET);

  frame_word_t    pending_words [$];   // frame words still owed by the block
  stim_row_t      directed_rows [$];

  int             error_count   = 0;
  int unsigned    sent_total    = 0;   // wire requests accepted, sender's count
  int unsigned    accepted_total = 0;  // same, counted by the scoreboard
  int             typed_seq     = -1;  // ordinal of the byte whose result is hand-written
  frame_word_t    typed_word;
  bit             quiet         = 1'b0;
  int unsigned    idle_pct      = 0;
  int unsigned    stall_pct     = 0;

  // Data byte into the frame; the limit is capped at the store size. Hitting
  // the limit counts one overflow and drops everything up to the next END.
  function automatic void store_frame_byte(input logic [7:0] b);
    int unsigned cap;
    cap = (max_len_cfg > STORE_BYTES) ? STORE_BYTES : max_len_cfg;
    if (dropping)
      return;
    if (stored_len >= cap) begin
      ovf_count++;
      stored_len = 0;
      dropping = 1'b1;
      return;
    end
    frame_bytes[stored_len] = b;
    stored_len++;
  endfunction

  // Real END on a non-empty frame: runt check, else split into LE words.
  function automatic void close_frame();
    frame_word_t w;
    int unsigned len;
    int unsigned nwords;
    int unsigned nb;
    len = stored_len;
    stored_len = 0;
    if (len < min_len_cfg) begin
      runt_count++;
      return;
    end
    good_count++;
    nwords = (len + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      nb = (len - 8 * k > 8) ? 8 : len - 8 * k;
      w = '0;
      for (int j = 0; j < nb; j++)
        w.data[8 * j +: 8] = frame_bytes[8 * k + j];
      w.nbytes = 4'(nb);
      w.last = (k == nwords - 1);
      w.len = FRAME_LEN_W'(len);
      w.good = good_count;
      w.runt = runt_count;
      w.ovf = ovf_count;
      pending_words.push_back(w);
    end
  endfunction

  function automatic void decode_wire_byte(input logic [7:0] b);
    if (esc_seen) begin
      // byte after ESC is always data, even an END
      esc_seen = 1'b0;
      if (b == BYTE_ESC_END)
        store_frame_byte(BYTE_END);
      else if (b == BYTE_ESC_ESC)
        store_frame_byte(BYTE_ESC);
      else
        store_frame_byte(b);
    end else if (b == BYTE_END) begin
      if (dropping) begin
        dropping = 1'b0;
        stored_len = 0;
      end else if (stored_len != 0) begin
        close_frame();
      end
    end else if (b == BYTE_ESC) begin
      esc_seen = 1'b1;
    end else begin
      store_frame_byte(b);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Scoreboard. Everything is sampled at the clock edge, before the NBA updates
  // of that edge, so the order of processes within the step does not matter.
  always @(posedge clk) begin : scoreboard
    frame_word_t want;
    int unsigned depth;
    if (!rst) begin
      if (in_valid && in_ready) begin
        depth = pending_words.size();
        decode_wire_byte(wire_byte);
        // hand-written expectation replaces what the model produced for this byte
        if (accepted_total == typed_seq) begin
          while (pending_words.size() > depth)
            void'(pending_words.pop_back());
          pending_words.push_back(typed_word);
        end
        accepted_total++;
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: frame word with none expected, expected nothing, actual data %h",
                   $time, frame_data);
          error_count++;
        end else begin
          want = pending_words.pop_front();
          check_field("frame_data", want.data, frame_data);
          check_field("valid_bytes", 64'(want.nbytes), 64'(valid_bytes));
          check_field("last_word", 64'(want.last), 64'(last_word));
          check_field("frame_length", 64'(want.len), 64'(frame_length));
          check_field("good_frame_total", 64'(want.good), 64'(good_frame_total));
          check_field("runt_frame_total", 64'(want.runt), 64'(runt_frame_total));
          check_field("overflow_total", 64'(want.ovf), 64'(overflow_total));
        end
      end
    end
  end

  // Receiver: out_ready drops in random bursts.
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One wire request, maybe after an idle burst. in_valid stays high on return
  // so back-to-back bytes never toggle it within a step.
  task automatic push_byte(input logic [7:0] b);
    if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    wire_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_total++;
  endtask

  // Data byte with SLIP stuffing applied.
  task automatic send_data_byte(input logic [7:0] b);
    if (b == BYTE_END) begin
      push_byte(BYTE_ESC);
      push_byte(BYTE_ESC_END);
    end else if (b == BYTE_ESC) begin
      push_byte(BYTE_ESC);
      push_byte(BYTE_ESC_ESC);
    end else begin
      push_byte(b);
    end
  endtask

  // Hold off until every owed word is out, then let runts/empties settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Both limits, back to back; the model follows at the write edge.
  task automatic configure(input int unsigned min_len, input int unsigned max_len);
    cfg_write_enable <= 1'b1;
    cfg_index <= REG_MIN_FRAME_LENGTH;
    cfg_data <= CFG_W'(min_len);
    @(posedge clk);
    min_len_cfg = min_len;
    cfg_index <= REG_MAX_FRAME_LENGTH;
    cfg_data <= CFG_W'(max_len);
    @(posedge clk);
    max_len_cfg = max_len;
    cfg_write_enable <= 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.wbyte = b;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_settings(input int unsigned min_len, input int unsigned max_len);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SETTINGS;
    r.min_len = CFG_W'(min_len);
    r.max_len = CFG_W'(max_len);
    directed_rows.push_back(r);
  endfunction

  // One-byte frame: result is obvious, so it is typed in.
  function automatic void add_single_frame(input logic [7:0] b, input logic [31:0] good);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.wbyte = b;
    directed_rows.push_back(r);
    r.wbyte = BYTE_END;
    r.typed = 1'b1;
    r.word.data = {56'd0, b};
    r.word.nbytes = 4'd1;
    r.word.last = 1'b1;
    r.word.len = FRAME_LEN_W'(1);
    r.word.good = good;
    directed_rows.push_back(r);
  endfunction

  initial begin : stimulus
    int unsigned flen;
    int unsigned phase_left;
    int unsigned pick;
    int unsigned cur_min;
    int unsigned cur_max;
    logic [7:0]  noise;

    rst <= 1'b1;
    in_valid <= 1'b0;
    wire_byte <= '0;
    cfg_write_enable <= 1'b0;
    cfg_index <= REG_MIN_FRAME_LENGTH;
    cfg_data <= '0;

    // Directed table. Minimum of one lets any non-empty frame through.
    add_settings(1, 296);
    add_byte(BYTE_END);                   // empty frame: nothing out
    add_single_frame(8'h00, 32'd1);       // lowest byte value
    add_single_frame(8'hFF, 32'd2);       // highest byte value
    add_byte(BYTE_ESC);                   // ESC ESC_END -> C0
    add_byte(BYTE_ESC_END);
    add_byte(BYTE_ESC);                   // ESC ESC_ESC -> DB
    add_byte(BYTE_ESC_ESC);
    add_byte(BYTE_ESC);                   // escaped END is plain data
    add_byte(BYTE_END);
    add_byte(BYTE_ESC);                   // ESC before an ordinary byte passes it
    add_byte(8'h41);
    add_byte(BYTE_END);
    add_settings(296, 296);               // highest minimum: short frame is a runt
    add_byte(8'h55);
    add_byte(BYTE_END);
    add_settings(1, 1);                   // lowest maximum: second byte overflows
    add_byte(8'h11);
    add_byte(8'h22);
    add_byte(8'h33);                      // dropped while discarding
    add_byte(BYTE_ESC);                   // escaped END while discarding: still data
    add_byte(BYTE_ESC_END);
    add_byte(BYTE_END);                   // real END ends discard, nothing out
    add_byte(8'h77);
    add_byte(BYTE_END);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    stall_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETTINGS) begin
        wait_idle();
        configure(32'(directed_rows[i].min_len), 32'(directed_rows[i].max_len));
      end else begin
        if (directed_rows[i].typed) begin
          typed_word = directed_rows[i].word;
          typed_seq = sent_total;
        end
        push_byte(directed_rows[i].wbyte);
      end
    end

    // Largest frame the store holds: every word slot gets used once.
    wait_idle();
    configure(1, 296);
    for (int i = 0; i < STORE_BYTES; i++)
      send_data_byte(8'($urandom_range(0, 255)));
    push_byte(BYTE_END);

    // Random part: phases of well-formed frames with random content, some stray
    // escapes and some noise. Each phase change waits for the block to go idle.
    phase_left = 0;
    cur_min = 1;
    cur_max = 296;
    while (sent_total < ITEM_TARGET) begin
      if (sent_total >= QUIET_AFTER)
        quiet = 1'b1;
      if (phase_left == 0) begin
        wait_idle();
        pick = $urandom_range(0, 19);
        cur_min = (pick == 0) ? 296 : (pick < 3) ? 1 : $urandom_range(1, 24);
        pick = $urandom_range(0, 19);
        cur_max = (pick == 0) ? 1 : (pick < 8) ? 296 :
                  (pick < 16) ? $urandom_range(8, 64) : $urandom_range(2, 296);
        configure(cur_min, cur_max);
        pick = $urandom_range(0, 2);
        idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
        pick = $urandom_range(0, 2);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
        phase_left = $urandom_range(4, 10);
      end
      phase_left--;

      if ($urandom_range(0, 99) < 15) begin
        // noise: loose ENDs, escapes and raw bytes
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1, 2: noise = BYTE_END;
            3, 4:    noise = BYTE_ESC;
            5:       noise = BYTE_ESC_END;
            6:       noise = BYTE_ESC_ESC;
            default: noise = 8'($urandom_range(0, 255));
          endcase
          push_byte(noise);
        end
      end else begin
        // frame length: around the limits now and then, mostly short
        pick = $urandom_range(0, 19);
        case (pick)
          0:       flen = cur_max;
          1:       flen = cur_max + 1;
          2:       flen = (cur_min > 1) ? cur_min - 1 : 1;
          3:       flen = cur_min;
          default: flen = (pick < 17) ? $urandom_range(1, 24) : $urandom_range(25, 64);
        endcase
        if (flen > 64)
          flen = $urandom_range(1, 24);
        for (int i = 0; i < flen; i++) begin
          pick = $urandom_range(0, 19);
          if (pick < 3) begin
            send_data_byte((pick == 0) ? BYTE_END : (pick == 1) ? BYTE_ESC : BYTE_ESC_END);
          end else if (pick == 3) begin
            // stray escape in front of an arbitrary byte
            push_byte(BYTE_ESC);
            push_byte(8'($urandom_range(0, 255)));
          end else begin
            send_data_byte(8'($urandom_range(0, 255)));
          end
        end
        push_byte(BYTE_END);
      end
    end

    // Drain: everything owed must come out, then a full drain time of silence.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
